/* rtl/core/murmur64a_key_hash_defines.svh */
// Assertion macros for the key hash block.
`ifndef MURMUR64A_KEY_HASH_DEFINES_SVH
`define MURMUR64A_KEY_HASH_DEFINES_SVH

// Same-cycle implication, idle during reset.
`define MKH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mkh check failed");

// Next-cycle implication, idle during reset.
`define MKH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mkh check failed");

// Next-cycle implication, also checked while reset is applied.
`define MKH_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("mkh reset check failed");

`endif

/* rtl/core/mkh_pkg.sv */
package mkh_pkg;

    localparam int WORD_W = 64;
    localparam int LEN_W  = 12;
    localparam int SEED_W = 32;
    localparam int TAIL_W = 3;

    localparam logic [63:0] MUL_CONST = 64'hc6a4a7935bd1e995;
    localparam logic [31:0] MUL_LO    = MUL_CONST[31:0];
    localparam logic [31:0] MUL_HI    = MUL_CONST[63:32];
    localparam int          SHIFT_AMT = 47;

    localparam logic [15:0] KEY_LEN_MAX = 16'd4095;
    localparam logic [31:0] SEED_RESET  = 32'd1;
    localparam int          FQ_DEPTH    = 2;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [LEN_W-1:0]  len;
        logic              first;
        logic              last;
        logic              empty;
        logic [TAIL_W-1:0] tail;
    } t_entry;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] operand;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] product;
    } t_mul_rsp;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_LH,
        MUL_HL,
        MUL_DONE
    } t_mul_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SEED,
        B_DISP,
        B_K1,
        B_K2,
        B_H,
        B_FIN,
        B_OUT
    } t_back_state;

endpackage

/* rtl/core/mkh_front.sv */
module mkh_front #(
    parameter int FQ_DEPTH = mkh_pkg::FQ_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [mkh_pkg::WORD_W-1:0]  i_key_word,
    input  logic [mkh_pkg::LEN_W-1:0]   i_key_length,
    input  logic                        i_first_word,
    input  logic                        i_last_word,
    output logic                        o_avail,
    input  logic                        i_take,
    output mkh_pkg::t_entry             o_entry
);

    localparam int PTR_W = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(FQ_DEPTH + 1);

    mkh_pkg::t_entry  r_mem [FQ_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    mkh_pkg::t_entry  cls;
    logic [15:0]      len_ext;
    logic [15:0]      len_c;
    logic             wr_en;
    logic             rd_en;

    // clamp length, derive tail count and empty-key flag
    always_comb begin
        len_ext   = 16'(i_key_length);
        len_c     = (len_ext > mkh_pkg::KEY_LEN_MAX) ? mkh_pkg::KEY_LEN_MAX : len_ext;
        cls.word  = i_key_word;
        cls.len   = len_c[mkh_pkg::LEN_W-1:0];
        cls.first = i_first_word;
        cls.last  = i_last_word;
        cls.empty = i_first_word && (len_c == 16'd0);
        cls.tail  = len_c[mkh_pkg::TAIL_W-1:0];
    end

    assign o_full  = (r_cnt == CNT_W'(FQ_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_take && o_avail;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (wr_en) begin
            n_wr = (r_wr == PTR_W'(FQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (rd_en) begin
            n_rd = (r_rd == PTR_W'(FQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({wr_en, rd_en})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= cls;
        end
    end

endmodule

/* rtl/core/mkh_mul.sv */
module mkh_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mkh_pkg::t_mul_req i_req,
    output mkh_pkg::t_mul_rsp o_rsp
);

    // x * M mod 2^64 from three 32x32 partial products, one per cycle
    mkh_pkg::t_mul_state r_state, n_state;
    logic [63:0] r_x;
    logic [63:0] r_lo;
    logic [31:0] r_cross;

    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] prod;
    logic        take;

    assign take = i_req.start && (r_state == mkh_pkg::MUL_IDLE || r_state == mkh_pkg::MUL_DONE);

    always_comb begin
        n_state = r_state;
        op_a    = i_req.operand[31:0];
        op_b    = mkh_pkg::MUL_LO;
        unique case (r_state)
            mkh_pkg::MUL_IDLE: begin
                if (i_req.start) n_state = mkh_pkg::MUL_LH;
            end
            mkh_pkg::MUL_LH: begin
                op_a    = r_x[31:0];
                op_b    = mkh_pkg::MUL_HI;
                n_state = mkh_pkg::MUL_HL;
            end
            mkh_pkg::MUL_HL: begin
                op_a    = r_x[63:32];
                op_b    = mkh_pkg::MUL_LO;
                n_state = mkh_pkg::MUL_DONE;
            end
            mkh_pkg::MUL_DONE: begin
                n_state = i_req.start ? mkh_pkg::MUL_LH : mkh_pkg::MUL_IDLE;
            end
            default: n_state = mkh_pkg::MUL_IDLE;
        endcase
        prod = 64'(op_a) * 64'(op_b);
    end

    assign o_rsp.done    = (r_state == mkh_pkg::MUL_DONE);
    assign o_rsp.product = {r_lo[63:32] + r_cross, r_lo[31:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mkh_pkg::MUL_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_x  <= i_req.operand;
            r_lo <= prod;
        end
        if (r_state == mkh_pkg::MUL_LH) begin
            r_cross <= prod[31:0];
        end
        if (r_state == mkh_pkg::MUL_HL) begin
            r_cross <= r_cross + prod[31:0];
        end
    end

endmodule

/* rtl/core/mkh_back.sv */
module mkh_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [mkh_pkg::SEED_W-1:0]  i_seed,
    input  logic                        i_avail,
    output logic                        o_take,
    input  mkh_pkg::t_entry             i_entry,
    output mkh_pkg::t_mul_req           o_mul_req,
    input  mkh_pkg::t_mul_rsp           i_mul_rsp,
    output logic                        o_out_valid,
    output logic [mkh_pkg::WORD_W-1:0]  o_out_hash,
    input  logic                        i_pop
);

    function automatic logic [63:0] xs47(input logic [63:0] x);
        return x ^ (x >> mkh_pkg::SHIFT_AMT);
    endfunction

    function automatic logic [63:0] tail_mask(input logic [2:0] n);
        logic [63:0] m;
        for (int b = 0; b < 8; b++) begin
            m[b*8 +: 8] = (3'(b) < n) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

    mkh_pkg::t_back_state r_state, n_state;
    logic [63:0] r_word, n_word;
    logic        r_last, n_last;
    logic        r_empty, n_empty;
    logic [63:0] r_h, n_h;
    logic [63:0] r_run, n_run;
    logic [2:0]  r_tail, n_tail;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_out_hash, n_out_hash;

    logic [63:0] prod;
    logic        done;

    assign prod = i_mul_rsp.product;
    assign done = i_mul_rsp.done;

    always_comb begin
        n_state           = r_state;
        n_word            = r_word;
        n_last            = r_last;
        n_empty           = r_empty;
        n_h               = r_h;
        n_run             = r_run;
        n_tail            = r_tail;
        n_out_valid       = r_out_valid && !i_pop;
        n_out_hash        = r_out_hash;
        o_take            = 1'b0;
        o_mul_req.start   = 1'b0;
        o_mul_req.operand = '0;
        unique case (r_state)
            mkh_pkg::B_IDLE: begin
                if (i_avail) begin
                    o_take  = 1'b1;
                    n_word  = i_entry.word;
                    n_last  = i_entry.last;
                    n_empty = i_entry.empty;
                    if (i_entry.first) begin
                        n_tail            = i_entry.tail;
                        o_mul_req.start   = 1'b1;
                        o_mul_req.operand = 64'(i_entry.len);
                        n_state           = mkh_pkg::B_SEED;
                    end else begin
                        n_h     = r_run;
                        n_state = mkh_pkg::B_DISP;
                    end
                end
            end
            mkh_pkg::B_SEED: begin
                if (done) begin
                    n_h     = 64'(i_seed) ^ prod;
                    n_state = mkh_pkg::B_DISP;
                end
            end
            mkh_pkg::B_DISP: begin
                o_mul_req.start = 1'b1;
                if (!r_last || (!r_empty && r_tail == 3'd0)) begin
                    o_mul_req.operand = r_word;
                    n_state           = mkh_pkg::B_K1;
                end else if (r_empty) begin
                    o_mul_req.operand = xs47(r_h);
                    n_state           = mkh_pkg::B_FIN;
                end else begin
                    o_mul_req.operand = r_h ^ (r_word & tail_mask(r_tail));
                    n_state           = mkh_pkg::B_H;
                end
            end
            mkh_pkg::B_K1: begin
                if (done) begin
                    o_mul_req.start   = 1'b1;
                    o_mul_req.operand = xs47(prod);
                    n_state           = mkh_pkg::B_K2;
                end
            end
            mkh_pkg::B_K2: begin
                if (done) begin
                    o_mul_req.start   = 1'b1;
                    o_mul_req.operand = r_h ^ prod;
                    n_state           = mkh_pkg::B_H;
                end
            end
            mkh_pkg::B_H: begin
                if (done) begin
                    if (r_last) begin
                        o_mul_req.start   = 1'b1;
                        o_mul_req.operand = xs47(prod);
                        n_state           = mkh_pkg::B_FIN;
                    end else begin
                        n_run   = prod;
                        n_state = mkh_pkg::B_IDLE;
                    end
                end
            end
            mkh_pkg::B_FIN: begin
                if (done) begin
                    n_h     = xs47(prod);
                    n_state = mkh_pkg::B_OUT;
                end
            end
            mkh_pkg::B_OUT: begin
                if (!r_out_valid || i_pop) begin
                    n_out_valid = 1'b1;
                    n_out_hash  = r_h;
                    n_run       = '0;
                    n_tail      = '0;
                    n_state     = mkh_pkg::B_IDLE;
                end
            end
            default: n_state = mkh_pkg::B_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_hash  = r_out_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mkh_pkg::B_IDLE;
            r_run       <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_run       <= n_run;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word     <= n_word;
        r_last     <= n_last;
        r_empty    <= n_empty;
        r_h        <= n_h;
        r_out_hash <= n_out_hash;
    end

endmodule

/* rtl/core/murmur64a_key_hash.sv */
// Words are taken one at a time; a middle full word costs k*M, mixed k*M and h*M.
// A first word adds the seed product; a last word adds the finalizer and the result load.
// A tail word needs only h*M before the finalizer; an empty key goes straight to it.
// Rate is set by the shared 32x32 multiplier: each 64-bit product takes three partial products.
// A 2-entry input queue and a 1-entry result register decouple the two sides.
// Reset is synchronous, active low: queues, state and result flag clear, seed returns to 1.
module murmur64a_key_hash #(
    parameter int FQ_DEPTH = mkh_pkg::FQ_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [mkh_pkg::WORD_W-1:0]  i_key_word,
    input  logic [mkh_pkg::LEN_W-1:0]   i_key_length,
    input  logic                        i_first_word,
    input  logic                        i_last_word,
    output logic                        empty,
    input  logic                        pop,
    output logic [mkh_pkg::WORD_W-1:0]  o_hash_value,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mkh_pkg::SEED_W-1:0]  i_cfg_data
);

    logic [mkh_pkg::SEED_W-1:0] r_seed;
    logic                       avail;
    logic                       take;
    logic                       out_valid;
    mkh_pkg::t_entry            entry;
    mkh_pkg::t_mul_req          mul_req;
    mkh_pkg::t_mul_rsp          mul_rsp;

    assign o_cfg_ready = 1'b1;
    assign empty       = !out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= mkh_pkg::SEED_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_seed <= i_cfg_data;
        end
    end

    mkh_front #(
        .FQ_DEPTH (FQ_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_key_word   (i_key_word),
        .i_key_length (i_key_length),
        .i_first_word (i_first_word),
        .i_last_word  (i_last_word),
        .o_avail      (avail),
        .i_take       (take),
        .o_entry      (entry)
    );

    mkh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    mkh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seed      (r_seed),
        .i_avail     (avail),
        .o_take      (take),
        .i_entry     (entry),
        .o_mul_req   (mul_req),
        .i_mul_rsp   (mul_rsp),
        .o_out_valid (out_valid),
        .o_out_hash  (o_hash_value),
        .i_pop       (pop)
    );

endmodule

/* rtl/core/mkh_checker.sv */
`include "murmur64a_key_hash_defines.svh"

module mkh_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       push,
    input logic                       full,
    input logic                       pop,
    input logic                       empty,
    input logic [mkh_pkg::WORD_W-1:0] o_hash_value
);

    // reset leaves no result waiting and room for input
    `MKH_ASSERT_RST(a_reset_clear, !i_rst_n, empty && !full)

    // a waiting result stays put until popped
    `MKH_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(o_hash_value))

    // the input queue fills only through an accepted item
    `MKH_ASSERT_NOW(a_full_by_push, $rose(full), $past(push))

endmodule

bind murmur64a_key_hash mkh_checker u_mkh_checker (.*);

/* dv/murmur64a_key_hash_test.sv */
`timescale 1ns / 1ps

module murmur64a_key_hash_test;

    localparam int  N_DIR        = 21;
    localparam int  N_PHASES     = 6;
    localparam int  PHASE_WORDS  = 292;
    localparam int  SETTLE_CYCLES = 100;
    localparam int  CYCLE_LIMIT  = 1000000;
    localparam logic [63:0] EMPTY_KEY_SEED1 = 64'hc6a4a7935bd064dc;

    typedef struct packed {
        logic [63:0] word;
        logic [11:0] len;
        logic        first;
        logic        last;
        logic        known;
        logic [63:0] hash;
    } t_key_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic [63:0] i_key_word = '0;
    logic [11:0] i_key_length = '0;
    logic        i_first_word = 1'b0;
    logic        i_last_word = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        full;
    logic        empty;
    logic        o_cfg_ready;
    logic [63:0] o_hash_value;

    // predictor state
    logic [31:0] seed_reg = mkh_pkg::SEED_RESET;
    logic [63:0] acc_hash = '0;
    logic [2:0]  tail_cnt = '0;

    logic [63:0] pending_hashes[$];
    t_key_row    dir_rows [N_DIR];
    logic [31:0] seed_plan [N_PHASES];
    int          words_sent = 0;
    int          hashes_checked = 0;
    int          error_count = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    bit          steady = 1'b0;

    murmur64a_key_hash dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_key_word   (i_key_word),
        .i_key_length (i_key_length),
        .i_first_word (i_first_word),
        .i_last_word  (i_last_word),
        .empty        (empty),
        .pop          (pop),
        .o_hash_value (o_hash_value),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d hashes still pending", $time, pending_hashes.size());
            $display("[murmur64a_key_hash] ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] mix_block(input logic [63:0] h, input logic [63:0] k);
        k = k * mkh_pkg::MUL_CONST;
        k = k ^ (k >> mkh_pkg::SHIFT_AMT);
        k = k * mkh_pkg::MUL_CONST;
        h = h ^ k;
        return h * mkh_pkg::MUL_CONST;
    endfunction

    // Folds one key word into the running hash; returns 1 when a hash is finished.
    function automatic bit fold_key_word(input logic [63:0] word, input logic [11:0] len,
                                         input bit first, input bit last,
                                         output logic [63:0] digest);
        logic [63:0] h;
        logic [63:0] mask;
        bit          empty_key;
        h = acc_hash;
        empty_key = 1'b0;
        digest = '0;
        // a 12-bit length never exceeds KEY_LEN_MAX, so no clamp applies
        if (first) begin
            h = {32'd0, seed_reg} ^ ({52'd0, len} * mkh_pkg::MUL_CONST);
            tail_cnt = len[2:0];
            empty_key = (len == 12'd0);
        end
        if (!last) begin
            acc_hash = mix_block(h, word);
            return 1'b0;
        end
        if (!empty_key) begin
            if (tail_cnt != 3'd0) begin
                mask = (64'd1 << {tail_cnt, 3'b000}) - 64'd1;
                h = (h ^ (word & mask)) * mkh_pkg::MUL_CONST;
            end else begin
                h = mix_block(h, word);
            end
        end
        h = h ^ (h >> mkh_pkg::SHIFT_AMT);
        h = h * mkh_pkg::MUL_CONST;
        h = h ^ (h >> mkh_pkg::SHIFT_AMT);
        digest = h;
        acc_hash = '0;
        tail_cnt = '0;
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Called right after a rising edge; returns right after the accepting edge.
    task automatic push_item(input logic [63:0] word, input logic [11:0] len,
                             input bit first, input bit last,
                             input bit known, input logic [63:0] known_hash);
        int          gap;
        logic [63:0] digest;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_key_word <= word;
        i_key_length <= len;
        i_first_word <= first;
        i_last_word <= last;
        @(posedge i_clk);
        while (full !== 1'b0) @(posedge i_clk);
        words_sent++;
        if (fold_key_word(word, len, first, last, digest))
            pending_hashes.push_back(known ? known_hash : digest);
    endtask

    task automatic load_seed(input logic [31:0] value);
        push <= 1'b0;
        while (pending_hashes.size() != 0) @(posedge i_clk);
        // trailing words with no hash may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_data <= value;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        seed_reg = value;
    endtask

    task automatic send_random_key();
        int r;
        int r2;
        int len;
        int nwords;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            push_item({$urandom, $urandom}, 12'($urandom_range(0, 4095)),
                      1'($urandom_range(0, 1)),
                      $urandom_range(0, 2) == 0, 1'b0, '0);
            return;
        end
        r2 = $urandom_range(0, 99);
        if (r2 < 50)
            len = $urandom_range(0, 16);
        else if (r2 < 85)
            len = $urandom_range(17, 80);
        else if (r2 < 99)
            len = $urandom_range(81, 400);
        else
            len = $urandom_range(401, 4095);
        nwords = (len == 0) ? 1 : (len + 7) / 8;
        // word count that may disagree with the length
        if (r < 16)
            nwords = $urandom_range(1, nwords + 2);
        for (int i = 0; i < nwords; i++)
            push_item({$urandom, $urandom},
                      (i == 0) ? 12'(len) : 12'($urandom_range(0, 4095)),
                      i == 0, i == nwords - 1, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            hashes_checked <= hashes_checked + 1;
            if (pending_hashes.size() == 0) begin
                $display("%0t: unexpected hash, expected none, got %h", $time, o_hash_value);
                error_count <= error_count + 1;
            end else begin
                if (o_hash_value !== pending_hashes[0]) begin
                    $display("%0t: hash mismatch, expected %h, got %h",
                             $time, pending_hashes[0], o_hash_value);
                    error_count <= error_count + 1;
                end
                void'(pending_hashes.pop_front());
            end
        end
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            pop <= 1'b0;
        end else if (!steady && i_rst_n && $urandom_range(0, 9) == 0) begin
            stall_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(10, 50)
                                                      : $urandom_range(1, 3);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    initial begin
        dir_rows[0]  = '{64'hffffffffffffffff, 12'd0,    1'b1, 1'b1, 1'b1, EMPTY_KEY_SEED1};
        dir_rows[1]  = '{64'hffffffffffffffff, 12'd1,    1'b1, 1'b1, 1'b0, 64'd0};
        dir_rows[2]  = '{64'h0123456789abcdef, 12'd7,    1'b1, 1'b1, 1'b0, 64'd0};
        dir_rows[3]  = '{64'h0000000000000000, 12'd8,    1'b1, 1'b1, 1'b0, 64'd0};
        dir_rows[4]  = '{64'hffffffffffffffff, 12'd8,    1'b1, 1'b1, 1'b0, 64'd0};
        dir_rows[5]  = '{64'h8000000000000000, 12'd16,   1'b1, 1'b0, 1'b0, 64'd0};
        dir_rows[6]  = '{64'h0000000000000001, 12'd0,    1'b0, 1'b1, 1'b0, 64'd0};
        dir_rows[7]  = '{64'h5a5a5a5aa5a5a5a5, 12'd4095, 1'b1, 1'b0, 1'b0, 64'd0};
        dir_rows[8]  = '{64'hdeadbeefcafef00d, 12'd4095, 1'b0, 1'b0, 1'b0, 64'd0};
        dir_rows[9]  = '{64'hffffffffffffffff, 12'd0,    1'b0, 1'b1, 1'b0, 64'd0};
        // words with no first word ahead of them
        dir_rows[10] = '{64'h1122334455667788, 12'd0,    1'b0, 1'b0, 1'b0, 64'd0};
        dir_rows[11] = '{64'h99aabbccddeeff00, 12'd0,    1'b0, 1'b1, 1'b0, 64'd0};
        // tail with junk in the ignored high bytes
        dir_rows[12] = '{64'h0f0f0f0f0f0f0f0f, 12'd11,   1'b1, 1'b0, 1'b0, 64'd0};
        dir_rows[13] = '{64'hffffffffff616263, 12'd0,    1'b0, 1'b1, 1'b0, 64'd0};
        dir_rows[14] = '{64'hffffffffffffffff, 12'd4095, 1'b1, 1'b1, 1'b0, 64'd0};
        // key restarted by a second first word
        dir_rows[15] = '{64'h0102030405060708, 12'd24,   1'b1, 1'b0, 1'b0, 64'd0};
        dir_rows[16] = '{64'h1112131415161718, 12'd13,   1'b1, 1'b0, 1'b0, 64'd0};
        dir_rows[17] = '{64'h2122232425262728, 12'd0,    1'b0, 1'b1, 1'b0, 64'd0};
        // zero length on a first word that is not last
        dir_rows[18] = '{64'h7fffffffffffffff, 12'd0,    1'b1, 1'b0, 1'b0, 64'd0};
        dir_rows[19] = '{64'hfffffffffffffffe, 12'd2048, 1'b0, 1'b1, 1'b0, 64'd0};
        dir_rows[20] = '{64'h0000000000000000, 12'd0,    1'b0, 1'b1, 1'b0, 64'd0};

        seed_plan[0] = 32'h00000000;
        seed_plan[1] = 32'hffffffff;
        seed_plan[2] = $urandom;
        seed_plan[3] = 32'h80000000;
        seed_plan[4] = $urandom;
        seed_plan[5] = mkh_pkg::SEED_RESET;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++)
            push_item(dir_rows[i].word, dir_rows[i].len, dir_rows[i].first, dir_rows[i].last,
                      dir_rows[i].known, dir_rows[i].hash);

        for (int p = 0; p < N_PHASES; p++) begin
            load_seed(seed_plan[p]);
            steady = (p == 3);
            if (seed_plan[p] == 32'd0)
                push_item({$urandom, $urandom}, 12'd0, 1'b1, 1'b1, 1'b1, 64'd0);
            while (words_sent < N_DIR + (p + 1) * PHASE_WORDS)
                send_random_key();
        end
        steady = 1'b0;

        push <= 1'b0;
        while (pending_hashes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Pushed %0d key words under %0d seed settings; %0d hashes checked, %0d bad.",
                 words_sent, N_PHASES + 1, hashes_checked, error_count);
        if (error_count == 0) begin
            $display("[murmur64a_key_hash] OK");
        end else begin
            $display("[murmur64a_key_hash] ERROR");
        end
        $finish;
    end

endmodule

/* murmur64a_key_hash.f */
+incdir+rtl/core
rtl/core/mkh_pkg.sv
rtl/core/mkh_front.sv
rtl/core/mkh_mul.sv
rtl/core/mkh_back.sv
rtl/core/murmur64a_key_hash.sv
rtl/core/mkh_checker.sv
dv/murmur64a_key_hash_test.sv
